[hw/rtl/htd_pkg.sv]
// ----------------------------------------------------------------------------
// htd_pkg: shared types and constants of the turbulence displacement block
// Register file layout, the bus between octave cells and fixed-point helpers.
// ----------------------------------------------------------------------------
package htd_pkg;

	localparam int MAX_OCTAVES = 8;

	localparam int DATA_W = 32;
	localparam int CNT_W  = 4;
	localparam int AMP_W  = 17;
	localparam int POS_W  = DATA_W + 1 + MAX_OCTAVES - 1;
	localparam int SUM_W  = AMP_W + $clog2(MAX_OCTAVES);

	localparam logic [AMP_W-1:0] ONE_Q16 = AMP_W'(65536);
	localparam logic signed [POS_W-1:0] LATTICE_OFFSET = POS_W'(100 * 65536);

	localparam logic [31:0] PRIME_X   = 32'd73856093;
	localparam logic [31:0] PRIME_Y   = 32'd19349663;
	localparam logic [31:0] PRIME_Z   = 32'd83492791;
	localparam logic [31:0] HASH_MASK = 32'h7fffffff;

	// floor(h / 1000) = (h * MOD_RECIP) >> MOD_SHIFT, exact for h below 2^31
	localparam logic [31:0] MOD_RECIP = 32'd2199023256;
	localparam int          MOD_SHIFT = 41;
	localparam logic [9:0]  MOD_BASE  = 10'd1000;
	localparam logic [9:0]  MOD_HALF  = 10'd500;

	// floor(d * 65536 / 500) = d * 131 + ((d * 37755) >> 19) for d up to 500
	localparam logic [16:0] NZ_INT        = 17'd131;
	localparam logic [24:0] NZ_FRAC       = 25'd37755;
	localparam int          NZ_FRAC_SHIFT = 19;

	localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7fff_ffff;
	localparam logic signed [63:0] SAT_MIN = 64'shffff_ffff_8000_0000;

	typedef enum logic [2:0] {
		REG_SCALE     = 3'd0,
		REG_INTENSITY = 3'd1,
		REG_OCTAVES   = 3'd2,
		REG_PERSIST   = 3'd3,
		REG_ANIM      = 3'd4,
		REG_SEED      = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] scale;
		logic signed [DATA_W-1:0] intensity;
		logic [CNT_W-1:0]         octave_count;
		logic [AMP_W-1:0]         persistence;
		logic signed [DATA_W-1:0] anim_speed;
		logic [DATA_W-1:0]        noise_seed;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		scale:        32'sd65536,
		intensity:    32'sd65536,
		octave_count: 4'd4,
		persistence:  17'd32768,
		anim_speed:   32'sd65536,
		noise_seed:   32'd12345
	};

	typedef struct packed {
		logic signed [POS_W-1:0] px0;
		logic signed [POS_W-1:0] px1;
		logic signed [POS_W-1:0] py0;
		logic signed [POS_W-1:0] py1;
		logic signed [POS_W-1:0] pz;
		logic [SUM_W-1:0]        sum0;
		logic [SUM_W-1:0]        sum1;
		logic [SUM_W-1:0]        sum2;
		logic [AMP_W-1:0]        amp;
		logic [CNT_W-1:0]        rem;
	} cell_bus_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > SAT_MAX) begin
			r = 32'sh7fff_ffff;
		end else if (x < SAT_MIN) begin
			r = 32'sh8000_0000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

[hw/rtl/htd_vtx_if.sv]
// ----------------------------------------------------------------------------
// htd_vtx_if: vertex input channel
// Position and time in signed Q16.16 with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface htd_vtx_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [31:0] time_now;

	modport source (output valid, output pos_x, output pos_y, output pos_z,
		output time_now, input ready);
	modport sink (input valid, input pos_x, input pos_y, input pos_z,
		input time_now, output ready);
endinterface

[hw/rtl/htd_disp_if.sv]
// ----------------------------------------------------------------------------
// htd_disp_if: displacement output channel
// Saturated displacement in signed Q16.16 with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface htd_disp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] disp_x;
	logic signed [31:0] disp_y;
	logic signed [31:0] disp_z;

	modport source (output valid, output disp_x, output disp_y, output disp_z,
		input ready);
	modport sink (input valid, input disp_x, input disp_y, input disp_z,
		output ready);
endinterface

[hw/rtl/htd_cfg_if.sv]
// ----------------------------------------------------------------------------
// htd_cfg_if: configuration write channel
// Register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface htd_cfg_if;
	logic                valid;
	logic                ready;
	htd_pkg::cfg_reg_t   index;
	logic [31:0]         data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/hashed_turbulence_displacement_top.sv]
// Throughput: one vertex per cycle unless the output stalls; every octave cell is a five-stage pipeline.
// The stall path runs back from the output register through every stage.
// Reset: configuration registers take their defaults and the pipeline empties.
// ----------------------------------------------------------------------------
// hashed_turbulence_displacement_top: vertex turbulence displacement
// Front scaling stage, a chain of octave cells and the output gain stage.
// ----------------------------------------------------------------------------
module hashed_turbulence_displacement_top (
	input  logic        clk,
	input  logic        arst_n,
	htd_cfg_if.sink     cfg,
	htd_vtx_if.sink     vtx,
	htd_disp_if.source  disp
);
	import htd_pkg::*;

	cfg_t             cfg_q;
	logic [AMP_W-1:0] pers_sat;

	cell_bus_t              bus [MAX_OCTAVES+1];
	logic [MAX_OCTAVES:0]   bus_valid;
	logic [MAX_OCTAVES:0]   bus_ready;

	assign cfg.ready = 1'b1;
	assign pers_sat  = (cfg_q.persistence > ONE_Q16) ? ONE_Q16 : cfg_q.persistence;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SCALE:     cfg_q.scale        <= cfg.data;
				REG_INTENSITY: cfg_q.intensity    <= cfg.data;
				REG_OCTAVES:   cfg_q.octave_count <= cfg.data[CNT_W-1:0];
				REG_PERSIST:   cfg_q.persistence  <= cfg.data[AMP_W-1:0];
				REG_ANIM:      cfg_q.anim_speed   <= cfg.data;
				REG_SEED:      cfg_q.noise_seed   <= cfg.data;
				default: ;
			endcase
		end
	end

	htd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.vtx       (vtx),
		.bus       (bus[0]),
		.bus_valid (bus_valid[0]),
		.bus_ready (bus_ready[0])
	);

	for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_cell
		htd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.seed     (cfg_q.noise_seed),
			.pers     (pers_sat),
			.up_bus   (bus[g]),
			.up_valid (bus_valid[g]),
			.up_ready (bus_ready[g]),
			.dn_bus   (bus[g+1]),
			.dn_valid (bus_valid[g+1]),
			.dn_ready (bus_ready[g+1])
		);
	end

	htd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.gain      (cfg_q.intensity),
		.bus       (bus[MAX_OCTAVES]),
		.bus_valid (bus_valid[MAX_OCTAVES]),
		.bus_ready (bus_ready[MAX_OCTAVES]),
		.disp      (disp)
	);
endmodule

[hw/rtl/htd_front.sv]
// ----------------------------------------------------------------------------
// htd_front: animation offset and spatial scaling
// Adds time times speed, multiplies by scale and seeds the octave chain.
// ----------------------------------------------------------------------------
module htd_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  htd_pkg::cfg_t         cfg,
	htd_vtx_if.sink               vtx,
	output htd_pkg::cell_bus_t    bus,
	output logic                  bus_valid,
	input  logic                  bus_ready
);
	import htd_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic en1, en2, en3, en4;

	logic signed [63:0] tprod_s1;
	logic signed [31:0] px_s1, py_s1, pz_s1;
	logic signed [31:0] ax_s2, ay_s2, az_s2;
	logic signed [63:0] sx_s3, sy_s3, sz_s3;
	cell_bus_t          bus_s4;

	logic signed [63:0] shift;
	logic signed [63:0] pxe, pye, pze;
	logic signed [63:0] sce;
	logic signed [31:0] vx, vy, vz;
	logic [CNT_W-1:0]   cnt;
	cell_bus_t          seed_bus;

	assign en4 = !vld_s4 || bus_ready;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;
	assign vtx.ready = en1;

	always_comb begin
		shift = tprod_s1 >>> 16;
		pxe   = px_s1;
		pye   = py_s1;
		pze   = pz_s1;
		sce   = cfg.scale;
		vx    = sat32(sx_s3 >>> 16);
		vy    = sat32(sy_s3 >>> 16);
		vz    = sat32(sz_s3 >>> 16);
		if (cfg.octave_count == '0) begin
			cnt = CNT_W'(1);
		end else if (int'(cfg.octave_count) > MAX_OCTAVES) begin
			cnt = CNT_W'(MAX_OCTAVES);
		end else begin
			cnt = cfg.octave_count;
		end
		seed_bus.px0  = POS_W'(vx);
		seed_bus.px1  = POS_W'(vx) + LATTICE_OFFSET;
		seed_bus.py0  = POS_W'(vy);
		seed_bus.py1  = POS_W'(vy) + LATTICE_OFFSET;
		seed_bus.pz   = POS_W'(vz);
		seed_bus.sum0 = '0;
		seed_bus.sum1 = '0;
		seed_bus.sum2 = '0;
		seed_bus.amp  = ONE_Q16;
		seed_bus.rem  = cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= vtx.valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			tprod_s1 <= 64'(vtx.time_now) * 64'(cfg.anim_speed);
			px_s1    <= vtx.pos_x;
			py_s1    <= vtx.pos_y;
			pz_s1    <= vtx.pos_z;
		end
		if (en2) begin
			ax_s2 <= sat32(pxe + shift);
			ay_s2 <= sat32(pye + shift);
			az_s2 <= sat32(pze + shift);
		end
		if (en3) begin
			sx_s3 <= 64'(ax_s2) * sce;
			sy_s3 <= 64'(ay_s2) * sce;
			sz_s3 <= 64'(az_s2) * sce;
		end
		if (en4) begin
			bus_s4 <= seed_bus;
		end
	end

	assign bus       = bus_s4;
	assign bus_valid = vld_s4;
endmodule

[hw/rtl/htd_cell.sv]
// ----------------------------------------------------------------------------
// htd_cell: one octave of the three turbulence sums
// Hashes the lattice point, adds the weighted noise and doubles the position.
// ----------------------------------------------------------------------------
module htd_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [31:0]                   seed,
	input  logic [htd_pkg::AMP_W-1:0]     pers,
	input  htd_pkg::cell_bus_t            up_bus,
	input  logic                          up_valid,
	output logic                          up_ready,
	output htd_pkg::cell_bus_t            dn_bus,
	output logic                          dn_valid,
	input  logic                          dn_ready
);
	import htd_pkg::*;

	function automatic logic [31:0] trunc_q16(input logic signed [POS_W-1:0] v);
		logic [15:0]         bias;
		logic signed [POS_W:0] s;
		logic signed [POS_W:0] q;
		bias = v[POS_W-1] ? 16'hffff : 16'h0000;
		s    = $signed({v[POS_W-1], v}) + $signed({{(POS_W + 1 - 16){1'b0}}, bias});
		q    = s >>> 16;
		return q[31:0];
	endfunction

	function automatic logic [16:0] noise_q16(input logic [30:0] h, input logic [21:0] q);
		logic [9:0]  m;
		logic [8:0]  d;
		logic [24:0] f;
		m = h[9:0] - 10'(q[9:0] * MOD_BASE);
		d = (m >= MOD_HALF) ? 9'(m - MOD_HALF) : 9'(MOD_HALF - m);
		f = 25'(d) * NZ_FRAC;
		return 17'(17'(d) * NZ_INT) + 17'(f[24:NZ_FRAC_SHIFT]);
	endfunction

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic en1, en2, en3, en4, en5;

	cell_bus_t   fwd_s1, fwd_s2, fwd_s3, fwd_s4, bus_s5;
	logic        act_s1, act_s2, act_s3, act_s4;
	logic [31:0] tx0_s1, tx1_s1, ty0_s1, ty1_s1, tz_s1;
	logic [31:0] mx0_s2, mx1_s2, my0_s2, my1_s2, mz_s2;
	logic [30:0] h0_s3, h1_s3, h2_s3;
	logic [21:0] q0_s3, q1_s3, q2_s3;
	logic [16:0] nz0_s4, nz1_s4, nz2_s4;

	logic        act;
	cell_bus_t   fwd;
	logic [31:0] h0, h1, h2;
	logic [62:0] r0, r1, r2;
	logic [33:0] w0, w1, w2, wa;
	cell_bus_t   nxt;

	assign en5 = !vld_s5 || dn_ready;
	assign en4 = !vld_s4 || en5;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;
	assign up_ready = en1;

	always_comb begin
		act     = (up_bus.rem != '0);
		fwd     = up_bus;
		fwd.px0 = up_bus.px0 <<< 1;
		fwd.px1 = up_bus.px1 <<< 1;
		fwd.py0 = up_bus.py0 <<< 1;
		fwd.py1 = up_bus.py1 <<< 1;
		fwd.pz  = up_bus.pz <<< 1;
		fwd.rem = act ? up_bus.rem - CNT_W'(1) : '0;

		h0 = (mx0_s2 ^ my0_s2 ^ mz_s2 ^ seed) & HASH_MASK;
		h1 = (mx1_s2 ^ my0_s2 ^ mz_s2 ^ seed) & HASH_MASK;
		h2 = (mx0_s2 ^ my1_s2 ^ mz_s2 ^ seed) & HASH_MASK;
		r0 = 63'(h0[30:0]) * 63'(MOD_RECIP);
		r1 = 63'(h1[30:0]) * 63'(MOD_RECIP);
		r2 = 63'(h2[30:0]) * 63'(MOD_RECIP);

		w0 = 34'(nz0_s4) * 34'(fwd_s4.amp);
		w1 = 34'(nz1_s4) * 34'(fwd_s4.amp);
		w2 = 34'(nz2_s4) * 34'(fwd_s4.amp);
		wa = 34'(fwd_s4.amp) * 34'(pers);
		nxt = fwd_s4;
		if (act_s4) begin
			nxt.sum0 = fwd_s4.sum0 + SUM_W'(w0[32:16]);
			nxt.sum1 = fwd_s4.sum1 + SUM_W'(w1[32:16]);
			nxt.sum2 = fwd_s4.sum2 + SUM_W'(w2[32:16]);
		end
		nxt.amp = wa[32:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= up_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			fwd_s1 <= fwd;
			act_s1 <= act;
			tx0_s1 <= trunc_q16(up_bus.px0);
			tx1_s1 <= trunc_q16(up_bus.px1);
			ty0_s1 <= trunc_q16(up_bus.py0);
			ty1_s1 <= trunc_q16(up_bus.py1);
			tz_s1  <= trunc_q16(up_bus.pz);
		end
		if (en2) begin
			fwd_s2 <= fwd_s1;
			act_s2 <= act_s1;
			mx0_s2 <= tx0_s1 * PRIME_X;
			mx1_s2 <= tx1_s1 * PRIME_X;
			my0_s2 <= ty0_s1 * PRIME_Y;
			my1_s2 <= ty1_s1 * PRIME_Y;
			mz_s2  <= tz_s1 * PRIME_Z;
		end
		if (en3) begin
			fwd_s3 <= fwd_s2;
			act_s3 <= act_s2;
			h0_s3  <= h0[30:0];
			h1_s3  <= h1[30:0];
			h2_s3  <= h2[30:0];
			q0_s3  <= r0[62:MOD_SHIFT];
			q1_s3  <= r1[62:MOD_SHIFT];
			q2_s3  <= r2[62:MOD_SHIFT];
		end
		if (en4) begin
			fwd_s4 <= fwd_s3;
			act_s4 <= act_s3;
			nz0_s4 <= noise_q16(h0_s3, q0_s3);
			nz1_s4 <= noise_q16(h1_s3, q1_s3);
			nz2_s4 <= noise_q16(h2_s3, q2_s3);
		end
		if (en5) begin
			bus_s5 <= nxt;
		end
	end

	assign dn_bus   = bus_s5;
	assign dn_valid = vld_s5;
endmodule

[hw/rtl/htd_back.sv]
// ----------------------------------------------------------------------------
// htd_back: output gain and saturation
// Multiplies the three sums by intensity and holds the result transaction.
// ----------------------------------------------------------------------------
module htd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic signed [31:0]    gain,
	input  htd_pkg::cell_bus_t    bus,
	input  logic                  bus_valid,
	output logic                  bus_ready,
	htd_disp_if.source            disp
);
	import htd_pkg::*;

	logic vld_s1, vld_s2;
	logic en1, en2;

	logic signed [63:0] gx_s1, gy_s1, gz_s1;
	logic signed [31:0] dx_s2, dy_s2, dz_s2;
	logic signed [63:0] ge;

	assign en2 = !vld_s2 || disp.ready;
	assign en1 = !vld_s1 || en2;
	assign bus_ready = en1;
	assign ge = gain;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= bus_valid;
			if (en2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			gx_s1 <= $signed({{(64 - SUM_W){1'b0}}, bus.sum0}) * ge;
			gy_s1 <= $signed({{(64 - SUM_W){1'b0}}, bus.sum1}) * ge;
			gz_s1 <= $signed({{(64 - SUM_W){1'b0}}, bus.sum2}) * ge;
		end
		if (en2) begin
			dx_s2 <= sat32(gx_s1 >>> 16);
			dy_s2 <= sat32(gy_s1 >>> 16);
			dz_s2 <= sat32(gz_s1 >>> 16);
		end
	end

	assign disp.valid  = vld_s2;
	assign disp.disp_x = dx_s2;
	assign disp.disp_y = dy_s2;
	assign disp.disp_z = dz_s2;
endmodule

[tb/htd_disp_checker.sv]
// ----------------------------------------------------------------------------
// htd_disp_checker: displacement predictor and scoreboard
// Tracks register writes, predicts the displacement of every accepted vertex
// in fixed point and compares each delivered displacement with the oldest
// prediction. Hands the queue depth and the failure count to the bench top.
// ----------------------------------------------------------------------------
module htd_disp_checker (
	input  logic clk,
	input  logic arst_n,
	htd_cfg_if   cfg,
	htd_vtx_if   vtx,
	htd_disp_if  disp,
	output int   pending,
	output int   errors
);
	import htd_pkg::*;

	localparam logic [31:0] HASH_PX   = 32'd73856093;
	localparam logic [31:0] HASH_PY   = 32'd19349663;
	localparam logic [31:0] HASH_PZ   = 32'd83492791;
	localparam logic [31:0] HASH_KEEP = 32'h7fffffff;
	localparam logic [31:0] MOD_SPAN  = 32'd1000;
	localparam logic [31:0] MOD_MID   = 32'd500;
	localparam longint      UNITY     = 65536;
	localparam longint      OFFSET    = 100 * 65536;
	localparam int          OCT_LIMIT = 8;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} disp_t;

	cfg_t  regs;
	disp_t predicted_q[$];
	int    fail_cnt;

	function automatic longint clamp32(longint v);
		if (v > longint'(32'sh7fffffff)) begin
			return longint'(32'sh7fffffff);
		end
		if (v < longint'(32'sh80000000)) begin
			return longint'(32'sh80000000);
		end
		return v;
	endfunction

	function automatic logic [31:0] lattice_coord(longint v, int oct);
		longint q;
		q = (v * (longint'(1) <<< oct)) / 65536;
		return q[31:0];
	endfunction

	function automatic longint turbulence_sum(longint x, longint y, longint z);
		int                cnt;
		longint unsigned   pers;
		longint unsigned   amp;
		longint unsigned   sum;
		longint unsigned   nz;
		logic [31:0]       h;
		logic [31:0]       m;
		logic [31:0]       d;
		cnt = int'(regs.octave_count);
		if (cnt < 1) begin
			cnt = 1;
		end
		if (cnt > OCT_LIMIT) begin
			cnt = OCT_LIMIT;
		end
		pers = (regs.persistence > UNITY) ? UNITY : longint'(regs.persistence);
		amp  = UNITY;
		sum  = 0;
		for (int i = 0; i < cnt; i++) begin
			h = (lattice_coord(x, i) * HASH_PX) ^ (lattice_coord(y, i) * HASH_PY)
				^ (lattice_coord(z, i) * HASH_PZ) ^ regs.noise_seed;
			h = h & HASH_KEEP;
			m = h % MOD_SPAN;
			d = (m >= MOD_MID) ? m - MOD_MID : MOD_MID - m;
			nz = ({32'd0, d} << 16) / {32'd0, MOD_MID};
			sum += (nz * amp) >> 16;
			amp = (amp * pers) >> 16;
		end
		return longint'(sum);
	endfunction

	function automatic disp_t predict_displacement(logic signed [31:0] px,
		logic signed [31:0] py, logic signed [31:0] pz, logic signed [31:0] tn);
		logic signed [31:0] src [3];
		longint             pos [3];
		longint             sums [3];
		longint             shift;
		longint             sc;
		longint             gain;
		longint             a;
		disp_t              r;
		src[0] = px;
		src[1] = py;
		src[2] = pz;
		shift = (longint'(tn) * longint'($signed(regs.anim_speed))) >>> 16;
		sc    = longint'($signed(regs.scale));
		gain  = longint'($signed(regs.intensity));
		for (int k = 0; k < 3; k++) begin
			a      = clamp32(longint'(src[k]) + shift);
			pos[k] = clamp32((a * sc) >>> 16);
		end
		sums[0] = turbulence_sum(pos[0], pos[1], pos[2]);
		sums[1] = turbulence_sum(pos[0] + OFFSET, pos[1], pos[2]);
		sums[2] = turbulence_sum(pos[0], pos[1] + OFFSET, pos[2]);
		r.x = 32'(clamp32((sums[0] * gain) >>> 16));
		r.y = 32'(clamp32((sums[1] * gain) >>> 16));
		r.z = 32'(clamp32((sums[2] * gain) >>> 16));
		return r;
	endfunction

	task automatic compare_field(string name, logic signed [31:0] want,
		logic signed [31:0] got);
		if (want !== got) begin
			$display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
			fail_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		disp_t want;
		if (!arst_n) begin
			regs = CFG_RESET;
			predicted_q.delete();
			fail_cnt = 0;
			pending <= 0;
			errors  <= 0;
		end else begin
			if (disp.valid && disp.ready) begin
				if (predicted_q.size() == 0) begin
					$display("%0t unexpected transaction: expected none, actual %h %h %h",
						$time, disp.disp_x, disp.disp_y, disp.disp_z);
					fail_cnt++;
				end else begin
					want = predicted_q.pop_front();
					compare_field("disp_x", want.x, disp.disp_x);
					compare_field("disp_y", want.y, disp.disp_y);
					compare_field("disp_z", want.z, disp.disp_z);
				end
			end
			if (vtx.valid && vtx.ready) begin
				predicted_q.push_back(predict_displacement(vtx.pos_x, vtx.pos_y,
					vtx.pos_z, vtx.time_now));
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_SCALE: begin
						regs.scale = cfg.data;
					end
					REG_INTENSITY: begin
						regs.intensity = cfg.data;
					end
					REG_OCTAVES: begin
						regs.octave_count = cfg.data[CNT_W-1:0];
					end
					REG_PERSIST: begin
						regs.persistence = cfg.data[AMP_W-1:0];
					end
					REG_ANIM: begin
						regs.anim_speed = cfg.data;
					end
					REG_SEED: begin
						regs.noise_seed = cfg.data;
					end
					default: begin
					end
				endcase
			end
			pending <= predicted_q.size();
			errors  <= fail_cnt;
		end
	end

endmodule

[tb/tb_hashed_turbulence_displacement_top.sv]
// ----------------------------------------------------------------------------
// tb_hashed_turbulence_displacement_top: turbulence displacement bench
// Drives vertices and register writes with random gaps and stalls, including
// a long output hold-off, and reports the scoreboard verdict.
// ----------------------------------------------------------------------------
module tb_hashed_turbulence_displacement_top;
	import htd_pkg::*;

	localparam int RESET_CYCLES  = 10;
	localparam int IDLE_LIMIT    = 3000;
	localparam int DRAIN_CYCLES  = 60;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_PHASES = 11;
	localparam int PHASE_ITEMS   = 100;
	localparam int HOLD_PHASE    = 2;

	localparam cfg_reg_t REG_UNUSED = cfg_reg_t'(3'd6);
	localparam cfg_reg_t REG_SPARE  = cfg_reg_t'(3'd7);

	localparam logic [31:0] S32_MAX    = 32'h7fffffff;
	localparam logic [31:0] S32_MIN    = 32'h80000000;
	localparam logic [31:0] Q16_ONE    = 32'h00010000;
	localparam logic [31:0] PERS_ONE   = 32'd65536;
	localparam logic [31:0] PERS_TOP   = 32'd131071;
	localparam logic [31:0] OCT_TOP    = 32'd15;
	localparam logic [31:0] OCT_NONE   = 32'd0;
	localparam logic [31:0] SMALL_SPAN = 32'h00200000;
	localparam logic [31:0] GAIN_SPAN  = 32'h00080000;

	logic clk;
	logic arst_n;
	int   pending;
	int   errors;
	int   idle_cycles;
	bit   hold_req;
	bit   no_gaps;

	htd_cfg_if  cfg_ch ();
	htd_vtx_if  vtx_ch ();
	htd_disp_if disp_ch ();

	hashed_turbulence_displacement_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.vtx    (vtx_ch),
		.disp   (disp_ch)
	);

	htd_disp_checker i_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.vtx     (vtx_ch),
		.disp    (disp_ch),
		.pending (pending),
		.errors  (errors)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic int gap_len();
		int r;
		if (no_gaps) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				return $urandom();
			end
			3: begin
				return $urandom_range(0, 1) ? S32_MAX : S32_MIN;
			end
			default: begin
				return $urandom_range(0, SMALL_SPAN) - (SMALL_SPAN >> 1);
			end
		endcase
	endfunction

	function automatic logic [31:0] rand_gain();
		case ($urandom_range(0, 9))
			8: begin
				return $urandom();
			end
			9: begin
				return $urandom_range(0, 1) ? S32_MAX : S32_MIN;
			end
			default: begin
				return $urandom_range(0, GAIN_SPAN) - (GAIN_SPAN >> 1);
			end
		endcase
	endfunction

	task automatic write_reg(cfg_reg_t idx, logic [31:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic send_vertex(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
		logic [31:0] tn);
		int g;
		g = gap_len();
		if (g > 0) begin
			vtx_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		vtx_ch.valid    <= 1'b1;
		vtx_ch.pos_x    <= px;
		vtx_ch.pos_y    <= py;
		vtx_ch.pos_z    <= pz;
		vtx_ch.time_now <= tn;
		do @(posedge clk); while (!vtx_ch.ready);
	endtask

	task automatic drain();
		vtx_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic send_corners();
		logic [31:0] corner [8];
		corner = '{32'h0, S32_MAX, S32_MIN, 32'hffffffff, Q16_ONE, 32'hffff0000,
			32'h00008000, 32'hffff8000};
		for (int k = 0; k < 8; k++) begin
			send_vertex(corner[k], corner[(k + 3) % 8], corner[(k + 5) % 8],
				corner[(k + 1) % 8]);
		end
	endtask

	// receiver: random ready, one long hold-off on request
	initial begin
		int run;
		int g;
		bit held;
		held = 1'b0;
		disp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req && !held) begin
				disp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				held = 1'b1;
			end else begin
				run = $urandom_range(1, 12);
				disp_ch.ready <= 1'b1;
				repeat (run) @(posedge clk);
				g = gap_len();
				if (g > 0) begin
					disp_ch.ready <= 1'b0;
					repeat (g) @(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (vtx_ch.valid && vtx_ch.ready) || (disp_ch.valid && disp_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_hashed_turbulence_displacement_top NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [31:0] pers;
		arst_n = 1'b0;
		hold_req = 1'b0;
		no_gaps = 1'b0;
		cfg_ch.valid    <= 1'b0;
		cfg_ch.index    <= REG_SCALE;
		cfg_ch.data     <= '0;
		vtx_ch.valid    <= 1'b0;
		vtx_ch.pos_x    <= '0;
		vtx_ch.pos_y    <= '0;
		vtx_ch.pos_z    <= '0;
		vtx_ch.time_now <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings
		send_corners();
		drain();

		// upper extremes, clamped octave count, persistence above one
		write_reg(REG_SCALE, S32_MAX);
		write_reg(REG_INTENSITY, S32_MAX);
		write_reg(REG_OCTAVES, OCT_TOP);
		write_reg(REG_PERSIST, PERS_TOP);
		write_reg(REG_ANIM, S32_MIN);
		write_reg(REG_SEED, 32'hffffffff);
		write_reg(REG_UNUSED, $urandom());
		write_reg(REG_SPARE, $urandom());
		cfg_ch.valid <= 1'b0;
		send_corners();
		drain();

		// lower extremes, zero octave count
		write_reg(REG_SCALE, S32_MIN);
		write_reg(REG_INTENSITY, S32_MIN);
		write_reg(REG_OCTAVES, OCT_NONE);
		write_reg(REG_PERSIST, '0);
		write_reg(REG_ANIM, S32_MAX);
		write_reg(REG_SEED, '0);
		cfg_ch.valid <= 1'b0;
		send_corners();
		send_vertex(Q16_ONE, Q16_ONE, Q16_ONE, '0);
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			pers = ($urandom_range(0, 4) == 0) ? $urandom_range(PERS_ONE + 1, PERS_TOP)
				: $urandom_range(0, PERS_ONE);
			write_reg(REG_SCALE, (p == 0) ? Q16_ONE : rand_gain());
			write_reg(REG_INTENSITY, rand_gain());
			write_reg(REG_OCTAVES, $urandom_range(0, OCT_TOP));
			write_reg(REG_PERSIST, (p == 1) ? PERS_ONE : pers);
			write_reg(REG_ANIM, rand_gain());
			write_reg(REG_SEED, $urandom());
			if ($urandom_range(0, 2) == 0) begin
				write_reg(REG_UNUSED, $urandom());
			end
			cfg_ch.valid <= 1'b0;
			no_gaps = (p % 4 == 3);
			if (p == HOLD_PHASE) begin
				hold_req = 1'b1;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_vertex(rand_coord(), rand_coord(), rand_coord(), rand_coord());
			end
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("tb_hashed_turbulence_displacement_top OK");
		end else begin
			$display("tb_hashed_turbulence_displacement_top NOT OK");
		end
		$finish;
	end

endmodule
